### hdl/shift_or_string_matcher_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the shift-or matcher.
// ----------------------------------------------------------------------------
`ifndef SHIFT_OR_STRING_MATCHER_UNIT_MACROS_SVH
`define SHIFT_OR_STRING_MATCHER_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SOM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define SOM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hdl/som_pkg.sv
// ----------------------------------------------------------------------------
// Shift-or matcher package
// Sizes, word types, register indexes and the byte folding function.
// ----------------------------------------------------------------------------
package som_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int OFFSET_BITS = 16;
    localparam int LEN_BITS    = $clog2(MAX_PATTERN + 1);
    localparam int SEL_BITS    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 6;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FOLD_CASE      = 2'd1;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEXT = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [4:0] pattern_index;
        logic [7:0] byte_value;
        logic       first_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic        hit;
        logic [15:0] match_start;
        logic        found;
        logic        string_end;
    } t_out_word;

    typedef struct packed {
        logic [CFG_INDEX_BITS-1:0] index;
        logic [CFG_DATA_BITS-1:0]  value;
    } t_cfg_word;

    // broadcast to every cell of the row
    typedef struct packed {
        logic       load;
        logic       step;
        logic       last;
        logic       fold;
        logic [7:0] raw;
        logic [7:0] text;
    } t_cell_ctl;

    function automatic logic [7:0] map_byte(input logic fold, input logic [7:0] b);
        if (fold && (b >= 8'h41) && (b <= 8'h5A)) begin
            return b + 8'h20;
        end
        return b;
    endfunction

endpackage

### hdl/som_if.sv
// ----------------------------------------------------------------------------
// Shift-or matcher channels
// Valid/ready channels for input words, result words and register writes.
// ----------------------------------------------------------------------------
interface som_in_if;
    import som_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface som_out_if;
    import som_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface som_cfg_if;
    import som_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/som_cell.sv
// ----------------------------------------------------------------------------
// Shift-or cell
// Holds one pattern byte and its mismatch bit; takes the bit of its left
// neighbour each text step.
// ----------------------------------------------------------------------------
module som_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  som_pkg::t_cell_ctl i_ctl,
    input  logic               i_wr_sel,
    input  logic               i_prev,
    input  logic               i_active,
    output logic               o_bit,
    output logic               o_next
);
    import som_pkg::*;

    logic [7:0] r_pattern;
    logic       r_bit;
    logic       n_bit;
    logic       w_miss;

    always_comb begin
        w_miss = (map_byte(i_ctl.fold, r_pattern) != i_ctl.text);
        n_bit  = (i_prev | w_miss) & i_active;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && i_wr_sel) begin
            r_pattern <= i_ctl.raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b1;
        end else if (i_ctl.step) begin
            // end of string restarts the row as all mismatching
            r_bit <= i_ctl.last ? 1'b1 : n_bit;
        end
    end

    assign o_bit  = r_bit;
    assign o_next = n_bit;

endmodule

### hdl/som_skid.sv
// ----------------------------------------------------------------------------
// Result skid buffer
// Output register plus one spare entry, so the row keeps taking words while
// a result waits.
// ----------------------------------------------------------------------------
`include "shift_or_string_matcher_unit_macros.svh"

module som_skid (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  som_pkg::t_out_word i_data,
    som_out_if.source          o_out
);
    import som_pkg::*;

    logic      r_main_valid;
    logic      r_skid_valid;
    t_out_word r_main;
    t_out_word r_skid;
    logic      w_in_fire;
    logic      w_out_fire;

    assign o_ready    = !r_skid_valid;
    assign w_in_fire  = i_valid && !r_skid_valid;
    assign w_out_fire = r_main_valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_main_valid || w_out_fire) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= w_in_fire;
            end
        end else if (w_in_fire) begin
            // main held: park the word
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_main_valid || w_out_fire) begin
            r_main <= r_skid_valid ? r_skid : i_data;
        end
        if (r_main_valid && !w_out_fire && w_in_fire) begin
            r_skid <= i_data;
        end
    end

    assign o_out.valid = r_main_valid;
    assign o_out.data  = r_main;

    `SOM_ASSERT_IMPL(a_skid_behind_main, i_clk, i_rst_n, r_skid_valid, r_main_valid)
    `SOM_ASSERT_NEXT(a_park_on_stall, i_clk, i_rst_n, r_main_valid && !o_out.ready && w_in_fire, r_skid_valid && r_main_valid)
    `SOM_ASSERT_NEXT(a_refill_from_skid, i_clk, i_rst_n, w_out_fire && r_skid_valid, r_main_valid && !r_skid_valid)

endmodule

### hdl/shift_or_string_matcher_unit.sv
// ----------------------------------------------------------------------------
// Shift-or string matcher
// Results: a result word is registered into the output buffer as its input
// word is accepted. Throughput: one word per cycle while the output buffer has
// room, set by the single compare stage of the cell row feeding a two-entry output buffer.
// Reset: synchronous active low; clears the mismatch row to all ones, offset
// and found flag to zero, pattern length to one and case folding off.
// Pattern bytes are not reset.
// ----------------------------------------------------------------------------
`include "shift_or_string_matcher_unit_macros.svh"

module shift_or_string_matcher_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    som_in_if.sink    i_in,
    som_out_if.source o_out,
    som_cfg_if.sink   i_cfg
);
    import som_pkg::*;

    logic [CFG_DATA_BITS-1:0] r_pattern_length;
    logic                     r_fold_case;
    logic [OFFSET_BITS-1:0]   r_offset;
    logic                     r_found;

    logic [LEN_BITS-1:0]    w_len;
    logic [SEL_BITS-1:0]    w_sel;
    logic [MAX_PATTERN-1:0] w_bit;
    logic [MAX_PATTERN-1:0] w_next;
    logic [MAX_PATTERN-1:0] w_prev;
    logic                   w_fire;
    logic                   w_step;
    logic                   w_skid_ready;
    logic [OFFSET_BITS-1:0] w_here;
    logic [OFFSET_BITS-1:0] w_start;
    logic                   w_found_eff;
    logic                   w_hit;
    t_cell_ctl              w_ctl;
    t_out_word              w_result;

    // register port
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_length <= CFG_DATA_BITS'(1);
            r_fold_case      <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                CFG_PATTERN_LENGTH: r_pattern_length <= i_cfg.data.value;
                CFG_FOLD_CASE:      r_fold_case      <= i_cfg.data.value[0];
                default: ;
            endcase
        end
    end

    // clamp length into 1..MAX_PATTERN
    always_comb begin
        if (r_pattern_length == '0) begin
            w_len = LEN_BITS'(1);
        end else if (32'(r_pattern_length) > MAX_PATTERN) begin
            w_len = LEN_BITS'(MAX_PATTERN);
        end else begin
            w_len = LEN_BITS'(r_pattern_length);
        end
        w_sel = SEL_BITS'(w_len - LEN_BITS'(1));
    end

    assign i_in.ready = w_skid_ready;
    assign w_fire     = i_in.valid && i_in.ready;
    assign w_step     = w_fire && (i_in.data.cmd == CMD_TEXT);

    always_comb begin
        w_ctl.load = w_fire && (i_in.data.cmd == CMD_LOAD);
        w_ctl.step = w_step;
        w_ctl.last = i_in.data.last_byte;
        w_ctl.fold = r_fold_case;
        w_ctl.raw  = i_in.data.byte_value;
        w_ctl.text = map_byte(r_fold_case, i_in.data.byte_value);
    end

    // shift in a match at the head; a new string sees all ones behind it
    assign w_prev[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < MAX_PATTERN; g++) begin : g_cell
            if (g > 0) begin : g_link
                assign w_prev[g] = i_in.data.first_byte ? 1'b1 : w_bit[g-1];
            end
            som_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (w_ctl),
                .i_wr_sel (32'(i_in.data.pattern_index) == g),
                .i_prev   (w_prev[g]),
                .i_active (w_len > LEN_BITS'(g)),
                .o_bit    (w_bit[g]),
                .o_next   (w_next[g])
            );
        end
    endgenerate

    always_comb begin
        w_here      = i_in.data.first_byte ? '0 : r_offset;
        w_found_eff = i_in.data.first_byte ? 1'b0 : r_found;
        w_hit       = !w_next[w_sel] && !w_found_eff;
        w_start     = w_here - OFFSET_BITS'(w_sel);
        if (i_in.data.cmd == CMD_TEXT) begin
            w_result.hit         = w_hit;
            w_result.match_start = w_hit ? 16'(w_start) : 16'd0;
            w_result.found       = w_found_eff || w_hit;
            w_result.string_end  = i_in.data.last_byte;
        end else begin
            w_result.hit         = 1'b0;
            w_result.match_start = 16'd0;
            w_result.found       = r_found;
            w_result.string_end  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_found  <= 1'b0;
        end else if (w_step) begin
            if (i_in.data.last_byte) begin
                r_offset <= '0;
                r_found  <= 1'b0;
            end else begin
                r_offset <= w_here + OFFSET_BITS'(1);
                r_found  <= w_found_eff || w_hit;
            end
        end
    end

    som_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fire),
        .o_ready (w_skid_ready),
        .i_data  (w_result),
        .o_out   (o_out)
    );

    `SOM_ASSERT_NEXT(a_string_end_clears, i_clk, i_rst_n, w_step && i_in.data.last_byte, r_offset == '0 && !r_found)
    `SOM_ASSERT_NEXT(a_load_keeps_state, i_clk, i_rst_n, w_fire && (i_in.data.cmd == CMD_LOAD), $stable(r_offset) && $stable(r_found) && $stable(w_bit))
    `SOM_ASSERT_IMPL(a_hit_sets_found, i_clk, i_rst_n, o_out.valid && o_out.data.hit, o_out.data.found)

endmodule

### bench/tb_shift_or_string_matcher_unit.sv
// ----------------------------------------------------------------------------
// Shift-or string matcher testbench
// Streams pattern loads and text strings through the matcher with random
// gaps on both handshakes, predicts every result word from a private model of
// the mismatch row, offset and found flag, and compares each field of each
// result in order. Covers short directed cases and random strings under many
// pattern length and case folding settings, some strings running on across a
// change of pattern length.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_shift_or_string_matcher_unit;
    import som_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int IDLE_PCT     = 18;
    localparam int RANDOM_WORDS = 1200;
    localparam int REPORT_LIMIT = 10;
    localparam int DRAIN_LIMIT  = 2000;

    logic i_clk;
    logic i_rst_n;

    som_in_if  in_bus ();
    som_out_if out_bus ();
    som_cfg_if cfg_bus ();

    shift_or_string_matcher_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    t_in_word  pending_words[$];
    t_out_word expected_results[$];
    logic      in_taken;
    logic      steady_flow;

    // private copy of the matcher state and registers
    logic [7:0]             pat_mem [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] miss_row;
    logic [OFFSET_BITS-1:0] text_offset;
    logic                   found_seen;
    logic [5:0]             reg_length;
    logic                   reg_fold;

    // pattern as last loaded by the stimulus, used to plant matches
    logic [7:0] pat_image [MAX_PATTERN];

    int fault_count;
    int words_queued;
    int text_seen;
    int hits_seen;
    int reg_writes;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int used_len(input logic [5:0] l);
        if (l == 0) begin
            return 1;
        end
        if (l > MAX_PATTERN) begin
            return MAX_PATTERN;
        end
        return l;
    endfunction

    function automatic logic [7:0] fold_byte(input logic fold_on, input logic [7:0] b);
        if (fold_on && b >= 8'h41 && b <= 8'h5A) begin
            return b + 8'h20;
        end
        return b;
    endfunction

    function automatic logic [7:0] vary_case(input logic fold_on, input logic [7:0] b);
        logic letter;
        letter = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
        if (fold_on && letter && $urandom_range(1) == 1) begin
            return b ^ 8'h20;
        end
        return b;
    endfunction

    // mostly a small alphabet in either case, so that matches are frequent
    function automatic logic [7:0] filler_byte();
        logic [7:0] b;
        int         r;
        r = $urandom_range(19);
        if (r < 14) begin
            b = 8'h61 + 8'($urandom_range(3));
            if ($urandom_range(1) == 1) begin
                b = b - 8'h20;
            end
        end else if (r < 17) begin
            b = 8'($urandom_range(255));
        end else begin
            case ($urandom_range(7))
                0: b = 8'h40;
                1: b = 8'h41;
                2: b = 8'h5A;
                3: b = 8'h5B;
                4: b = 8'h60;
                5: b = 8'h61;
                6: b = 8'h7A;
                default: b = 8'h7B;
            endcase
        end
        return b;
    endfunction

    task automatic start_new_string();
        miss_row    = '1;
        text_offset = '0;
        found_seen  = 1'b0;
    endtask

    task automatic shift_or_predict(input t_in_word w);
        t_out_word              r;
        int                     n;
        int                     i;
        logic [MAX_PATTERN:0]   keep;
        logic [MAX_PATTERN-1:0] diff;
        logic [7:0]             c;
        r = '0;
        if (w.cmd == CMD_LOAD) begin
            pat_mem[w.pattern_index] = w.byte_value;
            r.found = found_seen;
        end else begin
            text_seen++;
            if (w.first_byte) begin
                start_new_string();
            end
            n    = used_len(reg_length);
            keep = ({{MAX_PATTERN{1'b0}}, 1'b1} << n) - 1;
            c    = fold_byte(reg_fold, w.byte_value);
            diff = '0;
            for (i = 0; i < n; i++) begin
                if (fold_byte(reg_fold, pat_mem[i]) != c) begin
                    diff[i] = 1'b1;
                end
            end
            miss_row = ((miss_row << 1) | diff) & keep[MAX_PATTERN-1:0];
            if (!miss_row[n-1] && !found_seen) begin
                r.hit         = 1'b1;
                r.match_start = text_offset - 16'(n - 1);
                found_seen    = 1'b1;
                hits_seen++;
            end
            r.found      = found_seen;
            r.string_end = w.last_byte;
            text_offset  = text_offset + 1'b1;
            if (w.last_byte) begin
                start_new_string();
            end
        end
        expected_results.push_back(r);
    endtask

    task automatic report_fault(input string what, input t_out_word want, input t_out_word got);
        fault_count++;
        if (fault_count <= REPORT_LIMIT) begin
            $display("%0t %s: expected %0b/%0d/%0b/%0b, got %0b/%0d/%0b/%0b",
                     $realtime, what, want.hit, want.match_start, want.found, want.string_end,
                     got.hit, got.match_start, got.found, got.string_end);
        end
    endtask

    // predict on every accepted input word, check every accepted result word
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n) begin
            if (cfg_bus.valid && cfg_bus.ready) begin
                reg_writes++;
                case (cfg_bus.data.index)
                    CFG_PATTERN_LENGTH: reg_length = cfg_bus.data.value;
                    CFG_FOLD_CASE:      reg_fold   = cfg_bus.data.value[0];
                    default: ;
                endcase
            end
            if (in_bus.valid && in_bus.ready) begin
                shift_or_predict(in_bus.data);
            end
            if (out_bus.valid && out_bus.ready) begin
                if (expected_results.size() == 0) begin
                    report_fault("unexpected result word", '0, out_bus.data);
                end else begin
                    want = expected_results.pop_front();
                    if (out_bus.data.hit !== want.hit ||
                        out_bus.data.match_start !== want.match_start ||
                        out_bus.data.found !== want.found ||
                        out_bus.data.string_end !== want.string_end) begin
                        report_fault("result mismatch", want, out_bus.data);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        in_taken <= in_bus.valid && in_bus.ready;
    end

    // hold a word until taken, then advance or idle
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else if (!in_bus.valid || in_taken) begin
            if (pending_words.size() != 0 && (steady_flow || $urandom_range(99) >= IDLE_PCT)) begin
                in_bus.data  <= pending_words.pop_front();
                in_bus.valid <= 1'b1;
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        out_bus.ready <= i_rst_n && (steady_flow || $urandom_range(99) >= IDLE_PCT);
    end

    task automatic push_word(input t_in_word w);
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic push_load(input int idx, input logic [7:0] b);
        t_in_word w;
        w               = '0;
        w.cmd           = CMD_LOAD;
        w.pattern_index = 5'(idx);
        w.byte_value    = b;
        push_word(w);
    endtask

    task automatic push_text(input logic [7:0] b, input logic first_f, input logic last_f);
        t_in_word w;
        w            = '0;
        w.cmd        = CMD_TEXT;
        w.byte_value = b;
        w.first_byte = first_f;
        w.last_byte  = last_f;
        push_word(w);
    endtask

    task automatic wait_idle();
        do begin
            @(posedge i_clk);
        end while (pending_words.size() != 0 || in_bus.valid || expected_results.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        @(negedge i_clk);
        cfg_bus.data.index <= idx;
        cfg_bus.data.value <= val;
        cfg_bus.valid      <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!(cfg_bus.valid && cfg_bus.ready));
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic settle_and_write(input int len, input logic fold_on);
        wait_idle();
        write_reg(CFG_PATTERN_LENGTH, 6'(len));
        write_reg(CFG_FOLD_CASE, {5'($urandom_range(31)), fold_on});
    endtask

    // one string with planted full or near matches and some noise words
    task automatic queue_string(input int n, input logic fold_on);
        logic [7:0] text_buf[$];
        int         slen;
        int         pos;
        int         copies;
        int         m;
        int         k;
        logic       first_f;
        logic       last_f;
        t_in_word   noise;
        slen = $urandom_range(1, n + 10);
        for (k = 0; k < slen; k++) begin
            text_buf.push_back(filler_byte());
        end
        copies = (slen >= n && $urandom_range(9) < 6) ? $urandom_range(1, 2) : 0;
        repeat (copies) begin
            m   = (n > 1 && $urandom_range(3) == 0) ? n - 1 : n;
            pos = $urandom_range(0, slen - m);
            for (k = 0; k < m; k++) begin
                text_buf[pos+k] = vary_case(fold_on, pat_image[k]);
            end
        end
        for (k = 0; k < slen; k++) begin
            if ($urandom_range(99) < 8) begin
                noise.cmd           = 1'($urandom_range(1));
                noise.pattern_index = 5'($urandom_range(31));
                noise.byte_value    = 8'($urandom_range(255));
                noise.first_byte    = 1'($urandom_range(1));
                noise.last_byte     = 1'($urandom_range(1));
                push_word(noise);
            end
            first_f = (k == 0) ? ($urandom_range(99) < 85) : ($urandom_range(199) == 0);
            last_f  = (k == slen - 1) && ($urandom_range(99) < 90);
            push_text(text_buf[k], first_f, last_f);
        end
    endtask

    initial begin
        t_in_word w;
        int       random_start;
        int       seg;
        int       len;
        int       n;
        int       k;
        int       drain;
        logic     fold_on;

        in_bus.valid  = 1'b0;
        in_bus.data   = '0;
        out_bus.ready = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.data  = '0;
        in_taken      = 1'b0;
        steady_flow   = 1'b0;
        i_rst_n       = 1'b0;
        miss_row      = '1;
        text_offset   = '0;
        found_seen    = 1'b0;
        reg_length    = 6'd1;
        reg_fold      = 1'b0;
        fault_count   = 0;
        words_queued  = 0;
        text_seen     = 0;
        hits_seen     = 0;
        reg_writes    = 0;
        for (k = 0; k < MAX_PATTERN; k++) begin
            pat_image[k] = 8'h00;
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // single-byte pattern straight after reset
        push_load(0, 8'h61);
        push_text(8'h62, 1'b1, 1'b0);
        push_text(8'h61, 1'b0, 1'b0);
        push_text(8'h61, 1'b0, 1'b0);
        // a load carrying string flags must leave the string alone
        w               = '0;
        w.cmd           = CMD_LOAD;
        w.pattern_index = 5'd31;
        w.byte_value    = 8'hFF;
        w.first_byte    = 1'b1;
        w.last_byte     = 1'b1;
        push_word(w);
        push_text(8'h78, 1'b0, 1'b1);
        // new string opened by the previous end alone
        push_text(8'h61, 1'b0, 1'b1);
        push_text(8'hFF, 1'b1, 1'b0);
        push_text(8'h00, 1'b0, 1'b1);

        settle_and_write(3, 1'b1);
        push_load(0, 8'h41);
        push_load(1, 8'h62);
        push_load(2, 8'h43);
        push_text(8'h78, 1'b1, 1'b0);
        push_text(8'h61, 1'b0, 1'b0);
        push_text(8'h42, 1'b0, 1'b0);
        push_text(8'h63, 1'b0, 1'b0);
        push_text(8'h41, 1'b0, 1'b0);
        push_text(8'h62, 1'b0, 1'b0);
        push_text(8'h43, 1'b0, 1'b1);
        push_text(8'h61, 1'b1, 1'b0);
        push_text(8'h62, 1'b0, 1'b0);
        push_load(5, 8'h00);
        push_text(8'h63, 1'b0, 1'b1);
        // restart mid-match drops the partial match
        push_text(8'h61, 1'b1, 1'b0);
        push_text(8'h62, 1'b0, 1'b0);
        push_text(8'h63, 1'b1, 1'b1);

        // zero length counts as one
        settle_and_write(0, 1'b0);
        push_text(8'h61, 1'b1, 1'b0);
        push_text(8'h41, 1'b0, 1'b1);

        random_start = words_queued;
        seg = 0;
        while (words_queued - random_start < RANDOM_WORDS) begin
            case (seg)
                0: len = 32;
                1: len = 63;
                2: len = 1;
                default: begin
                    case ($urandom_range(9))
                        0: len = 0;
                        1: len = 32;
                        2: len = $urandom_range(33, 63);
                        3: len = $urandom_range(7, 31);
                        default: len = $urandom_range(1, 6);
                    endcase
                end
            endcase
            fold_on = (seg < 3) ? seg[0] ^ 1'b1 : 1'($urandom_range(1));
            settle_and_write(len, fold_on);
            steady_flow = (seg >= 4 && seg < 8);
            n = used_len(6'(len));
            for (k = 0; k < n; k++) begin
                pat_image[k] = filler_byte();
                push_load(k, pat_image[k]);
            end
            repeat ($urandom_range(2, 5)) queue_string(n, fold_on);
            seg++;
        end

        do begin
            @(posedge i_clk);
        end while (pending_words.size() != 0 || in_bus.valid);
        steady_flow = 1'b0;
        drain = 0;
        while (expected_results.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (5) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $display("%0d result words never arrived", expected_results.size());
            fault_count += expected_results.size();
        end

        $display("Ran %0d input words (%0d text bytes, %0d hits), %0d register writes,",
                 words_queued, text_seen, hits_seen, reg_writes);
        $display("pattern lengths 0 to 63 with and without case folding; %0d faults seen.",
                 fault_count);
        if (fault_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### shift_or_string_matcher_unit.f
+incdir+hdl
hdl/som_pkg.sv
hdl/som_if.sv
hdl/som_cell.sv
hdl/som_skid.sv
hdl/shift_or_string_matcher_unit.sv
bench/tb_shift_or_string_matcher_unit.sv
